// ----- rtl/hbkrd_pkg.sv -----
// ----------------------------------------------------------------------------
// HID boot keyboard report differ package
// Shared constants and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package hbkrd_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int CANDS       = 2 * KEY_SLOTS;
  localparam int TREE_LEVELS = (CANDS > 1) ? $clog2(CANDS) : 1;
  localparam int TREE_SIZE   = 1 << TREE_LEVELS;

  localparam logic [7:0] FIRST_USAGE = 8'h04;
  localparam logic [7:0] END_USAGE   = 8'hE0;
  localparam logic [6:0] MIN_LENGTH  = 7'd8;

  localparam logic [7:0] CTRL_MASK  = 8'h11;
  localparam logic [7:0] SHIFT_MASK = 8'h22;
  localparam logic [7:0] ALT_MASK   = 8'h44;

  typedef struct packed {
    logic load;
    logic eval;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic report_ok;
    logic pending;
    logic out_free;
    logic final_pick;
  } status_t;

endpackage

// ----- rtl/hid_boot_keyboard_report_differ.sv -----
// ----------------------------------------------------------------------------
// HID boot keyboard report differ
// A report is captured in the idle state, then its changes are evaluated, and
// its events are then registered at the output one by one from the scan state.
// Throughput: one event per cycle while the output is free. A rejected report
// is taken while idle and dropped; a new report waits until the scan has ended.
// Reset clears the stored previous key slots to zero and drops pending events.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_report_differ (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       transfer_ok,
  input  logic [6:0] report_length,
  input  logic [7:0] modifier_byte,
  input  logic [7:0] key_slot_0,
  input  logic [7:0] key_slot_1,
  input  logic [7:0] key_slot_2,
  input  logic [7:0] key_slot_3,
  input  logic [7:0] key_slot_4,
  input  logic [7:0] key_slot_5,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] key_usage,
  output logic       is_release,
  output logic       ctrl_held,
  output logic       shift_held,
  output logic       alt_held,
  output logic       last_event
);

  hbkrd_pkg::cmd_t    cmd;
  hbkrd_pkg::status_t status;

  hbkrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hbkrd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .transfer_ok   (transfer_ok),
    .report_length (report_length),
    .modifier_byte (modifier_byte),
    .key_slot_0    (key_slot_0),
    .key_slot_1    (key_slot_1),
    .key_slot_2    (key_slot_2),
    .key_slot_3    (key_slot_3),
    .key_slot_4    (key_slot_4),
    .key_slot_5    (key_slot_5),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .key_usage     (key_usage),
    .is_release    (is_release),
    .ctrl_held     (ctrl_held),
    .shift_held    (shift_held),
    .alt_held      (alt_held),
    .last_event    (last_event)
  );

endmodule

// ----- rtl/hbkrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// HID boot keyboard report differ controller
// Sequences capture, change evaluation and the ordered emission of events.
// ----------------------------------------------------------------------------
module hbkrd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hbkrd_pkg::status_t status,
  output hbkrd_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && status.report_ok) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status.pending) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.final_pick) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/hbkrd_datapath.sv -----
// ----------------------------------------------------------------------------
// HID boot keyboard report differ datapath
// Holds the key slots, marks changed usages and picks the lowest one per step.
// ----------------------------------------------------------------------------
module hbkrd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  hbkrd_pkg::cmd_t     cmd,
  output hbkrd_pkg::status_t  status,
  input  logic               transfer_ok,
  input  logic [6:0]         report_length,
  input  logic [7:0]         modifier_byte,
  input  logic [7:0]         key_slot_0,
  input  logic [7:0]         key_slot_1,
  input  logic [7:0]         key_slot_2,
  input  logic [7:0]         key_slot_3,
  input  logic [7:0]         key_slot_4,
  input  logic [7:0]         key_slot_5,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         key_usage,
  output logic               is_release,
  output logic               ctrl_held,
  output logic               shift_held,
  output logic               alt_held,
  output logic               last_event
);

  logic [7:0] slot_in [hbkrd_pkg::KEY_SLOTS];
  logic [7:0] cur     [hbkrd_pkg::KEY_SLOTS];
  logic [7:0] prev    [hbkrd_pkg::KEY_SLOTS];
  logic [7:0] mods;

  logic [7:0]                 cand_val [hbkrd_pkg::CANDS];
  logic [hbkrd_pkg::CANDS-1:0] mask;
  logic [hbkrd_pkg::CANDS-1:0] rel;

  logic [7:0]                 cand_val_next [hbkrd_pkg::CANDS];
  logic [hbkrd_pkg::CANDS-1:0] mask_next;
  logic [hbkrd_pkg::CANDS-1:0] rel_next;

  logic [7:0] tv [hbkrd_pkg::TREE_LEVELS+1][hbkrd_pkg::TREE_SIZE];
  logic       tk [hbkrd_pkg::TREE_LEVELS+1][hbkrd_pkg::TREE_SIZE];
  logic       tr [hbkrd_pkg::TREE_LEVELS+1][hbkrd_pkg::TREE_SIZE];

  logic [7:0]                 pick_val;
  logic                       pick_rel;
  logic [hbkrd_pkg::CANDS-1:0] match;
  logic [hbkrd_pkg::CANDS-1:0] mask_left;

  assign slot_in[0] = key_slot_0;
  assign slot_in[1] = key_slot_1;
  assign slot_in[2] = key_slot_2;
  assign slot_in[3] = key_slot_3;
  assign slot_in[4] = key_slot_4;
  assign slot_in[5] = key_slot_5;

  // A usage is a candidate when it is in range and present on one side only.
  always_comb begin
    logic hit;
    for (int j = 0; j < hbkrd_pkg::KEY_SLOTS; j++) begin
      hit = 1'b0;
      for (int k = 0; k < hbkrd_pkg::KEY_SLOTS; k++) begin
        hit = hit | (cur[j] == prev[k]);
      end
      cand_val_next[j] = cur[j];
      rel_next[j]      = 1'b0;
      mask_next[j]     = !hit && (cur[j] >= hbkrd_pkg::FIRST_USAGE) &&
                         (cur[j] < hbkrd_pkg::END_USAGE);
    end
    for (int j = 0; j < hbkrd_pkg::KEY_SLOTS; j++) begin
      hit = 1'b0;
      for (int k = 0; k < hbkrd_pkg::KEY_SLOTS; k++) begin
        hit = hit | (prev[j] == cur[k]);
      end
      cand_val_next[hbkrd_pkg::KEY_SLOTS+j] = prev[j];
      rel_next[hbkrd_pkg::KEY_SLOTS+j]      = 1'b1;
      mask_next[hbkrd_pkg::KEY_SLOTS+j]     = !hit &&
                                              (prev[j] >= hbkrd_pkg::FIRST_USAGE) &&
                                              (prev[j] < hbkrd_pkg::END_USAGE);
    end
  end

  // Minimum tree over the pending candidates.
  always_comb begin
    for (int i = 0; i < hbkrd_pkg::TREE_SIZE; i++) begin
      if (i < hbkrd_pkg::CANDS) begin
        tv[0][i] = cand_val[i];
        tk[0][i] = mask[i];
        tr[0][i] = rel[i];
      end else begin
        tv[0][i] = '0;
        tk[0][i] = 1'b0;
        tr[0][i] = 1'b0;
      end
    end
    for (int l = 0; l < hbkrd_pkg::TREE_LEVELS; l++) begin
      for (int i = 0; i < hbkrd_pkg::TREE_SIZE / 2; i++) begin
        if (tk[l][2*i] && (!tk[l][2*i+1] || (tv[l][2*i] <= tv[l][2*i+1]))) begin
          tv[l+1][i] = tv[l][2*i];
          tk[l+1][i] = 1'b1;
          tr[l+1][i] = tr[l][2*i];
        end else begin
          tv[l+1][i] = tv[l][2*i+1];
          tk[l+1][i] = tk[l][2*i+1];
          tr[l+1][i] = tr[l][2*i+1];
        end
      end
      for (int i = hbkrd_pkg::TREE_SIZE / 2; i < hbkrd_pkg::TREE_SIZE; i++) begin
        tv[l+1][i] = '0;
        tk[l+1][i] = 1'b0;
        tr[l+1][i] = 1'b0;
      end
    end
    pick_val = tv[hbkrd_pkg::TREE_LEVELS][0];
    pick_rel = tr[hbkrd_pkg::TREE_LEVELS][0];
    for (int j = 0; j < hbkrd_pkg::CANDS; j++) begin
      match[j] = (cand_val[j] == pick_val);
    end
    mask_left = mask & ~match;
  end

  assign status.report_ok  = transfer_ok && (report_length >= hbkrd_pkg::MIN_LENGTH);
  assign status.pending    = |mask;
  assign status.out_free   = !out_valid || out_ready;
  assign status.final_pick = (mask_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < hbkrd_pkg::KEY_SLOTS; j++) begin
        prev[j] <= '0;
      end
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.eval) begin
        for (int j = 0; j < hbkrd_pkg::KEY_SLOTS; j++) begin
          prev[j] <= cur[j];
        end
        mask <= mask_next;
      end else if (cmd.emit) begin
        mask <= mask_left;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < hbkrd_pkg::KEY_SLOTS; j++) begin
        cur[j] <= slot_in[j];
      end
      mods <= modifier_byte;
    end
    if (cmd.eval) begin
      for (int j = 0; j < hbkrd_pkg::CANDS; j++) begin
        cand_val[j] <= cand_val_next[j];
      end
      rel <= rel_next;
    end
    if (cmd.emit) begin
      key_usage  <= pick_val;
      is_release <= pick_rel;
      ctrl_held  <= |(mods & hbkrd_pkg::CTRL_MASK);
      shift_held <= |(mods & hbkrd_pkg::SHIFT_MASK);
      alt_held   <= |(mods & hbkrd_pkg::ALT_MASK);
      last_event <= status.final_pick;
    end
  end

endmodule

// ----- dv/hid_boot_keyboard_report_differ_tb.sv -----
// ----------------------------------------------------------------------------
// HID boot keyboard report differ testbench
// A directed table covers reset state, rejected and short reports, usages at
// and beyond both ends of the range, duplicate slots, unchanged reports and the
// most events one report can cause. A random part follows, mostly well-formed
// reports that keep some keys held from the last report. Both sides idle at
// random, the receiver once holds off long enough to back up the input, and
// the sender pauses between phases until every expected event has arrived.
// Every output transfer is checked against the table's event or a predictor.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_report_differ_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 20;

  typedef struct packed {
    logic                                 transfer_ok;
    logic [6:0]                           report_length;
    logic [7:0]                           modifier_byte;
    logic [hbkrd_pkg::KEY_SLOTS-1:0][7:0] slots;
  } report_t;

  typedef struct packed {
    logic [7:0] key_usage;
    logic       is_release;
    logic       ctrl_held;
    logic       shift_held;
    logic       alt_held;
    logic       last_event;
  } key_event_t;

  typedef struct packed {
    report_t    rpt;
    logic       typed;
    logic       has_event;
    key_event_t ev;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic out_valid;
  logic out_ready;
  logic [7:0] key_usage;
  logic is_release;
  logic ctrl_held;
  logic shift_held;
  logic alt_held;
  logic last_event;

  row_t drive;
  logic [hbkrd_pkg::KEY_SLOTS-1:0][7:0] held_keys;
  logic [hbkrd_pkg::KEY_SLOTS-1:0][7:0] sent_slots;
  key_event_t fresh_events[$];
  key_event_t events_due[$];
  row_t script[$];
  bit steady;
  bit hold_off_req;
  int errors = 0;
  int idle_cycles = 0;

  hid_boot_keyboard_report_differ dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .transfer_ok   (drive.rpt.transfer_ok),
    .report_length (drive.rpt.report_length),
    .modifier_byte (drive.rpt.modifier_byte),
    .key_slot_0    (drive.rpt.slots[0]),
    .key_slot_1    (drive.rpt.slots[1]),
    .key_slot_2    (drive.rpt.slots[2]),
    .key_slot_3    (drive.rpt.slots[3]),
    .key_slot_4    (drive.rpt.slots[4]),
    .key_slot_5    (drive.rpt.slots[5]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .key_usage     (key_usage),
    .is_release    (is_release),
    .ctrl_held     (ctrl_held),
    .shift_held    (shift_held),
    .alt_held      (alt_held),
    .last_event    (last_event)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic row_t mk_row(input int ok, input int len,
                                  input logic [7:0] mods, input logic [47:0] slots,
                                  input int typed = 0, input int has_ev = 0,
                                  input key_event_t ev = '0);
    row_t r;
    r.rpt.transfer_ok   = 1'(ok);
    r.rpt.report_length = 7'(len);
    r.rpt.modifier_byte = mods;
    r.rpt.slots         = slots;
    r.typed             = 1'(typed);
    r.has_event         = 1'(has_ev);
    r.ev                = ev;
    return r;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int pick;
    r = '0;
    r.rpt.modifier_byte = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 82) begin
      r.rpt.transfer_ok   = 1'b1;
      r.rpt.report_length = 7'($urandom_range(hbkrd_pkg::MIN_LENGTH, 64));
    end else begin
      r.rpt.transfer_ok   = 1'($urandom_range(0, 1));
      r.rpt.report_length = r.rpt.transfer_ok ?
                            7'($urandom_range(0, hbkrd_pkg::MIN_LENGTH - 1)) :
                            7'($urandom_range(0, 64));
    end
    for (int i = 0; i < hbkrd_pkg::KEY_SLOTS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        r.rpt.slots[i] = sent_slots[$urandom_range(0, hbkrd_pkg::KEY_SLOTS - 1)];
      end else if (pick < 65) begin
        r.rpt.slots[i] = 8'h00;
      end else if (pick < 90) begin
        r.rpt.slots[i] = 8'($urandom_range(hbkrd_pkg::FIRST_USAGE,
                                           hbkrd_pkg::END_USAGE - 1));
      end else begin
        r.rpt.slots[i] = 8'($urandom_range(0, 255));
      end
    end
    return r;
  endfunction

  // Computes the key events one report causes and, if accepted, stores its slots.
  task automatic predict_report(input report_t rpt);
    key_event_t ev;
    logic now_has;
    logic old_has;
    fresh_events.delete();
    if (!rpt.transfer_ok || rpt.report_length < hbkrd_pkg::MIN_LENGTH) return;
    ev = '0;
    ev.ctrl_held  = |(rpt.modifier_byte & hbkrd_pkg::CTRL_MASK);
    ev.shift_held = |(rpt.modifier_byte & hbkrd_pkg::SHIFT_MASK);
    ev.alt_held   = |(rpt.modifier_byte & hbkrd_pkg::ALT_MASK);
    for (int u = hbkrd_pkg::FIRST_USAGE; u < hbkrd_pkg::END_USAGE; u++) begin
      now_has = 1'b0;
      old_has = 1'b0;
      for (int i = 0; i < hbkrd_pkg::KEY_SLOTS; i++) begin
        if (rpt.slots[i] == u) now_has = 1'b1;
        if (held_keys[i] == u) old_has = 1'b1;
      end
      if (now_has != old_has && fresh_events.size() < hbkrd_pkg::CANDS) begin
        ev.key_usage  = 8'(u);
        ev.is_release = old_has;
        fresh_events.push_back(ev);
      end
    end
    if (fresh_events.size() > 0) begin
      ev = fresh_events.pop_back();
      ev.last_event = 1'b1;
      fresh_events.push_back(ev);
    end
    held_keys = rpt.slots;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    key_event_t got;
    key_event_t want;
    bit progress;
    if (!rst) begin
      progress = 1'b0;
      if (out_valid && out_ready) begin
        progress = 1'b1;
        got = {key_usage, is_release, ctrl_held, shift_held, alt_held, last_event};
        if (events_due.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected event, expected none, got usage %0h release %0b",
                   $time, got.key_usage, got.is_release);
        end else begin
          want = events_due.pop_front();
          check_field("key_usage", want.key_usage, got.key_usage);
          check_field("is_release", want.is_release, got.is_release);
          check_field("ctrl_held", want.ctrl_held, got.ctrl_held);
          check_field("shift_held", want.shift_held, got.shift_held);
          check_field("alt_held", want.alt_held, got.alt_held);
          check_field("last_event", want.last_event, got.last_event);
        end
      end
      if (in_valid && in_ready) begin
        progress = 1'b1;
        predict_report(drive.rpt);
        if (drive.typed) begin
          if (drive.has_event) events_due.push_back(drive.ev);
        end else begin
          foreach (fresh_events[i]) events_due.push_back(fresh_events[i]);
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int rx_wait;
    rx_wait = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rx_wait = HOLD_OFF_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else if (steady || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_wait = pick_gap();
      end
    end
  end

  task automatic offer(input row_t r);
    @(negedge clk);
    drive    <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_tx(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    row_t r;
    rst          = 1'b1;
    in_valid     = 1'b0;
    drive        = '0;
    held_keys    = '0;
    sent_slots   = '0;
    steady       = 1'b0;
    hold_off_req = 1'b0;

    // Rows: transfer_ok, length, modifiers, slots 5 down to 0.
    script.push_back(mk_row(1, 8,  8'hFF, 48'h00_00_00_00_00_04, 1, 1,
                            '{8'h04, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}));
    script.push_back(mk_row(0, 8,  8'h00, 48'h00_00_00_00_00_DF, 1, 0));
    script.push_back(mk_row(1, 7,  8'h00, 48'h00_00_00_00_00_DF, 1, 0));
    script.push_back(mk_row(1, 0,  8'hFF, 48'hFF_FF_FF_FF_FF_FF, 1, 0));
    script.push_back(mk_row(1, 64, 8'h00, 48'h00_00_00_00_00_04, 1, 0));
    script.push_back(mk_row(1, 63, 8'h11, 48'h00_00_00_00_00_DF));
    script.push_back(mk_row(1, 8,  8'h22, 48'hFF_E0_03_02_01_00));
    script.push_back(mk_row(1, 9,  8'h44, 48'h05_05_05_05_05_05));
    script.push_back(mk_row(1, 40, 8'h00, 48'hDF_DE_30_20_10_04));
    script.push_back(mk_row(1, 64, 8'hAA, 48'h50_40_31_21_11_05));
    script.push_back(mk_row(0, 64, 8'hFF, 48'h00_00_00_00_00_00, 1, 0));
    script.push_back(mk_row(1, 8,  8'h55, 48'h00_00_00_00_00_00));
    script.push_back(mk_row(1, 32, 8'h80, 48'hFF_E1_E0_04_03_00));
    script.push_back(mk_row(1, 16, 8'h08, 48'hFF_FF_FF_FF_FF_FF));
    script.push_back(mk_row(1, 8,  8'h00, 48'h00_00_00_00_00_00, 1, 0));
    script.push_back(mk_row(1, 8,  8'h33, 48'hDF_04_DF_04_DF_04));

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      offer(script[i]);
      pause_tx(pick_gap());
    end
    sent_slots = script[script.size() - 1].rpt.slots;
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      steady = (phase == 1);
      if (phase == 2) hold_off_req = 1'b1;
      repeat (phase == 0 ? 64 : phase == 1 ? 40 : 45) begin
        r = random_row();
        sent_slots = r.rpt.slots;
        offer(r);
        pause_tx(steady ? 0 : pick_gap());
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hbkrd_pkg.sv
rtl/hbkrd_ctrl.sv
rtl/hbkrd_datapath.sv
rtl/hid_boot_keyboard_report_differ.sv
dv/hid_boot_keyboard_report_differ_tb.sv
